[sv/stks_pkg.sv]
// Package for the streaming top-K selector: sizes, reset floor and request types.
// Used by every module of the block; depends on nothing else.
package stks_pkg;

    localparam int K_SLOTS       = 10;
    localparam int SCORE_BITS    = 32;
    localparam int POSITION_BITS = 16;
    localparam int FLOOR_BITS    = 32;
    localparam int RANK_BITS     = 6;
    localparam int SLOT_BITS     = (SCORE_BITS > FLOOR_BITS) ? SCORE_BITS : FLOOR_BITS;
    localparam int CNT_BITS      = (K_SLOTS > 1) ? $clog2(K_SLOTS) : 1;

    localparam logic signed [FLOOR_BITS-1:0] FLOOR_RESET = -32'sd655360000;

    typedef logic signed [SLOT_BITS-1:0] slot_score_t;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic [POSITION_BITS-1:0]     position;
        logic                         final_item;
    } in_req_t;

    typedef struct packed {
        logic [RANK_BITS-1:0]         rank;
        logic signed [SCORE_BITS-1:0] kept_score;
        logic [POSITION_BITS-1:0]     kept_position;
        logic                         filled;
        logic                         run_end;
    } out_req_t;

    typedef struct packed {
        logic                load_item;
        logic                emit_slot;
        logic                last_slot;
        logic [CNT_BITS-1:0] emit_rank;
    } stks_cmd_t;

    typedef struct packed {
        logic out_free;
    } stks_status_t;

endpackage

[sv/streaming_top_k_select_unit.sv]
// Streaming top-K selector: in the collect state a non-final request is taken every cycle
// and inserted into the slot registers as it is taken. A final request is inserted too; the
// controller then moves to its emission state, and the K results leave the slot shift chain
// through the output register one per cycle while m_ready allows, with input held off.
// Reset is synchronous and active low: the floor returns to FLOOR_RESET (-655360000), all slots empty.
// Depends on stks_pkg, stks_ctrl and stks_datapath.
module streaming_top_k_select_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stks_pkg::in_req_t   s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output stks_pkg::out_req_t  m_req,
    input  logic                floor_wr_en,
    input  logic [31:0]         floor_wr_data
);
    import stks_pkg::*;

    stks_cmd_t    cmd;
    stks_status_t status;

    stks_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .final_item (s_req.final_item),
        .status     (status),
        .cmd        (cmd)
    );

    stks_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .floor_wr_en   (floor_wr_en),
        .floor_wr_data (floor_wr_data),
        .s_req         (s_req),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_req         (m_req)
    );

endmodule

[sv/stks_ctrl.sv]
// Controller of the streaming top-K selector: collects items, then sequences emission.
// Depends on stks_pkg for the command and status types.
module stks_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  final_item,
    input  stks_pkg::stks_status_t status,
    output stks_pkg::stks_cmd_t    cmd
);
    import stks_pkg::*;

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic                state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                last_now;

    assign s_ready  = (state_reg == ST_COLLECT);
    assign last_now = (count_reg == CNT_BITS'(K_SLOTS - 1));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmd.load_item = 1'b0;
        cmd.emit_slot = 1'b0;
        cmd.last_slot = last_now;
        cmd.emit_rank = count_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (final_item) begin
                        state_next = ST_EMIT;
                        count_next = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_slot = 1'b1;
                    if (last_now) begin
                        state_next = ST_COLLECT;
                        count_next = '0;
                    end else begin
                        count_next = CNT_BITS'(count_reg + 1'b1);
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

[sv/stks_datapath.sv]
// Datapath of the streaming top-K selector: sorted slot registers, parallel insertion,
// shift-out emission and the output register. Depends on stks_pkg.
module stks_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    floor_wr_en,
    input  logic [31:0]             floor_wr_data,
    input  stks_pkg::in_req_t       s_req,
    input  stks_pkg::stks_cmd_t     cmd,
    output stks_pkg::stks_status_t  status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output stks_pkg::out_req_t      m_req
);
    import stks_pkg::*;

    slot_score_t              score_reg [K_SLOTS];
    slot_score_t              score_next[K_SLOTS];
    logic [POSITION_BITS-1:0] pos_reg   [K_SLOTS];
    logic [POSITION_BITS-1:0] pos_next  [K_SLOTS];
    logic [K_SLOTS-1:0]       fill_reg, fill_next;
    logic [K_SLOTS-1:0]       gt;
    logic signed [FLOOR_BITS-1:0] floor_reg;
    slot_score_t              score_ext, floor_ext;
    logic                     out_valid_reg;
    out_req_t                 out_req_reg;

    assign score_ext       = slot_score_t'(s_req.score);
    assign floor_ext       = slot_score_t'(floor_reg);
    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_req           = out_req_reg;

    always_comb begin
        for (int i = 0; i < K_SLOTS; i++) begin
            gt[i]         = score_ext > score_reg[i];
            score_next[i] = score_reg[i];
            pos_next[i]   = pos_reg[i];
            fill_next[i]  = fill_reg[i];
        end
        if (cmd.load_item) begin
            for (int i = 0; i < K_SLOTS; i++) begin
                if (i < K_SLOTS - 1 && gt[(i < K_SLOTS - 1) ? i + 1 : i]) begin
                    score_next[i] = score_reg[(i < K_SLOTS - 1) ? i + 1 : i];
                    pos_next[i]   = pos_reg[(i < K_SLOTS - 1) ? i + 1 : i];
                    fill_next[i]  = fill_reg[(i < K_SLOTS - 1) ? i + 1 : i];
                end else if (gt[i]) begin
                    score_next[i] = score_ext;
                    pos_next[i]   = s_req.position;
                    fill_next[i]  = 1'b1;
                end
            end
        end else if (cmd.emit_slot) begin
            for (int i = 0; i < K_SLOTS; i++) begin
                if (i < K_SLOTS - 1) begin
                    score_next[i] = score_reg[(i < K_SLOTS - 1) ? i + 1 : i];
                    pos_next[i]   = pos_reg[(i < K_SLOTS - 1) ? i + 1 : i];
                    fill_next[i]  = fill_reg[(i < K_SLOTS - 1) ? i + 1 : i];
                end else begin
                    score_next[i] = floor_ext;
                    pos_next[i]   = '0;
                    fill_next[i]  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
            fill_reg  <= '0;
            for (int i = 0; i < K_SLOTS; i++) begin
                score_reg[i] <= slot_score_t'(FLOOR_RESET);
                pos_reg[i]   <= '0;
            end
        end else if (floor_wr_en) begin
            floor_reg <= floor_wr_data;
            fill_reg  <= '0;
            for (int i = 0; i < K_SLOTS; i++) begin
                score_reg[i] <= slot_score_t'($signed(floor_wr_data));
                pos_reg[i]   <= '0;
            end
        end else begin
            fill_reg <= fill_next;
            for (int i = 0; i < K_SLOTS; i++) begin
                score_reg[i] <= score_next[i];
                pos_reg[i]   <= pos_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_slot) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_slot) begin
            out_req_reg.rank          <= RANK_BITS'(cmd.emit_rank);
            out_req_reg.kept_score    <= score_reg[0][SCORE_BITS-1:0];
            out_req_reg.kept_position <= pos_reg[0];
            out_req_reg.filled        <= fill_reg[0];
            out_req_reg.run_end       <= cmd.last_slot;
        end
    end

endmodule

[sv/stks_checker.sv]
// Port-level checker for the streaming top-K selector, bound to the top level.
// Depends on stks_pkg and streaming_top_k_select_unit.
module stks_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input stks_pkg::out_req_t  m_req
);
    import stks_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result request dropped before it was taken");

    a_no_input_mid_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_req.run_end |-> !s_ready)
        else $error("input taken while a result list is still going out");

    a_rank_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_req.run_end |=>
            m_valid && (m_req.rank == RANK_BITS'($past(m_req.rank) + 1'b1)))
        else $error("result list has a gap or a rank out of order");

    a_run_end_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_req.run_end |-> m_req.rank == RANK_BITS'(K_SLOTS - 1))
        else $error("list end flagged on the wrong slot");

endmodule

bind streaming_top_k_select_unit stks_checker u_stks_checker (.*);

[tb/sv/stks_rank_checker.sv]
`timescale 1ns / 100ps
// Result checker for the streaming top-K selector testbench: keeps its own ranked slots,
// predicts the slot list for every final request and compares it with the result channel.
// Depends on stks_pkg.
module stks_rank_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  stks_pkg::in_req_t   s_req,
    input  logic                m_valid,
    input  logic                m_ready,
    input  stks_pkg::out_req_t  m_req,
    input  logic                floor_wr_en,
    input  logic [31:0]         floor_wr_data,
    output int                  mismatch_count,
    output int                  pending_results
);

    localparam int K = stks_pkg::K_SLOTS;

    stks_pkg::slot_score_t                floor_q;
    stks_pkg::slot_score_t                slot_score_q [K];
    logic [stks_pkg::POSITION_BITS-1:0]   slot_pos_q [K];
    logic                                 slot_fill_q [K];
    stks_pkg::out_req_t                   ranked_queue [$];
    stks_pkg::out_req_t                   want;
    int                                   errors = 0;

    task automatic clear_slots();
        for (int i = 0; i < K; i++) begin
            slot_score_q[i] = floor_q;
            slot_pos_q[i]   = '0;
            slot_fill_q[i]  = 1'b0;
        end
    endtask

    task automatic take_score(input stks_pkg::in_req_t req);
        stks_pkg::slot_score_t sc;
        stks_pkg::out_req_t    slot_out;
        int                    hit;
        sc  = $signed(req.score);
        hit = -1;
        for (int j = K - 1; j >= 0; j--) begin
            if (hit < 0 && sc > slot_score_q[j]) begin
                hit = j;
            end
        end
        if (hit >= 0) begin
            for (int k = 0; k < hit; k++) begin
                slot_score_q[k] = slot_score_q[k + 1];
                slot_pos_q[k]   = slot_pos_q[k + 1];
                slot_fill_q[k]  = slot_fill_q[k + 1];
            end
            slot_score_q[hit] = sc;
            slot_pos_q[hit]   = req.position;
            slot_fill_q[hit]  = 1'b1;
        end
        if (req.final_item) begin
            for (int k = 0; k < K; k++) begin
                slot_out.rank          = k[stks_pkg::RANK_BITS-1:0];
                slot_out.kept_score    = slot_score_q[k][stks_pkg::SCORE_BITS-1:0];
                slot_out.kept_position = slot_pos_q[k];
                slot_out.filled        = slot_fill_q[k];
                slot_out.run_end       = (k == K - 1);
                ranked_queue.push_back(slot_out);
            end
            clear_slots();
        end
    endtask

    task automatic report_field(input string name, input longint exp_v, input longint act_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            floor_q = stks_pkg::FLOOR_RESET;
            clear_slots();
            ranked_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (ranked_queue.size() == 0) begin
                    $display("%0t: unexpected request, expected none, actual %0h",
                             $time, m_req);
                    errors++;
                end else begin
                    want = ranked_queue.pop_front();
                    if (m_req !== want) begin
                        if (m_req.rank !== want.rank)
                            report_field("rank", want.rank, m_req.rank);
                        if (m_req.kept_score !== want.kept_score)
                            report_field("kept_score", want.kept_score, m_req.kept_score);
                        if (m_req.kept_position !== want.kept_position)
                            report_field("kept_position", want.kept_position,
                                         m_req.kept_position);
                        if (m_req.filled !== want.filled)
                            report_field("filled", want.filled, m_req.filled);
                        if (m_req.run_end !== want.run_end)
                            report_field("run_end", want.run_end, m_req.run_end);
                        errors++;
                    end
                end
            end
            if (floor_wr_en) begin
                floor_q = $signed(floor_wr_data);
                clear_slots();
            end
            if (s_valid && s_ready) begin
                take_score(s_req);
            end
        end
        pending_results <= ranked_queue.size();
        mismatch_count  <= errors;
    end

endmodule

[tb/sv/streaming_top_k_select_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the streaming top-K selector: drives score requests and floor writes,
// applies random back-pressure and gives the verdict from the rank checker's count.
// Depends on stks_pkg, streaming_top_k_select_unit and stks_rank_checker.
module streaming_top_k_select_unit_tb;

    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_ITEMS      = 62;

    typedef enum int {
        MODE_WIDE,
        MODE_NEAR_FLOOR,
        MODE_TIES,
        MODE_RAMP
    } score_mode_e;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                m_ready       = 1'b0;
    logic                floor_wr_en   = 1'b0;
    logic [31:0]         floor_wr_data = '0;
    stks_pkg::in_req_t   s_req         = '0;
    logic                s_ready;
    logic                m_valid;
    stks_pkg::out_req_t  m_req;
    int                  mismatch_count;
    int                  pending_results;
    bit                  tx_idle_on    = 1'b1;
    bit                  rx_idle_on    = 1'b1;
    bit                  long_hold_req = 1'b0;
    logic [31:0]         floor_now     = stks_pkg::FLOOR_RESET;

    streaming_top_k_select_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req         (s_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_req         (m_req),
        .floor_wr_en   (floor_wr_en),
        .floor_wr_data (floor_wr_data)
    );

    stks_rank_checker u_rank_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req           (s_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_req           (m_req),
        .floor_wr_en     (floor_wr_en),
        .floor_wr_data   (floor_wr_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic send_score(input logic [31:0] sc, input logic [15:0] pos, input logic fin);
        stks_pkg::in_req_t req;
        int                gap;
        req.score      = sc;
        req.position   = pos;
        req.final_item = fin;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_floor(input logic [31:0] value);
        drain_results();
        floor_wr_en   <= 1'b1;
        floor_wr_data <= value;
        floor_now      = value;
        @(posedge aclk);
        floor_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_score(input score_mode_e mode, input int idx);
        case (mode)
            MODE_WIDE:       return $urandom;
            MODE_NEAR_FLOOR: return floor_now + $urandom_range(0, 6) - 3;
            MODE_TIES:       return ($urandom_range(0, 7) - 3) * 65536;
            default:         return floor_now + idx * 4096 + 1;
        endcase
    endfunction

    initial begin
        int          sent;
        int          len;
        score_mode_e mode;
        logic [15:0] pos;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_score(32'h8000_0000, 16'hFFFF, 1'b1);
        send_score(32'hD8F0_0000, 16'd0, 1'b0);
        send_score(32'h7FFF_FFFF, 16'd0, 1'b0);
        send_score(32'h0001_0000, 16'd1, 1'b0);
        send_score(32'h0001_0000, 16'd2, 1'b0);
        send_score(32'hFFFF_0000, 16'd3, 1'b0);
        send_score(32'hD8F0_0001, 16'd4, 1'b0);
        send_score(32'h0002_0000, 16'd5, 1'b0);
        send_score(32'h0001_0000, 16'd6, 1'b0);
        send_score(32'hFFFF_0000, 16'd7, 1'b0);
        send_score(32'h0003_0000, 16'd8, 1'b0);
        send_score(32'h0004_0000, 16'd9, 1'b0);
        send_score(32'h0005_0000, 16'd10, 1'b0);
        send_score(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        send_score(32'h0001_8000, 16'd12, 1'b1);

        write_floor(32'h8000_0000);
        send_score(32'h8000_0000, 16'd0, 1'b0);
        send_score(32'h8000_0001, 16'hFFFF, 1'b0);
        send_score(32'h7FFF_FFFF, 16'd0, 1'b1);

        write_floor(32'h7FFF_FFFF);
        send_score(32'h7FFF_FFFF, 16'h5555, 1'b1);

        write_floor(32'h0000_0000);
        send_score(32'hFFFF_FFFF, 16'd0, 1'b0);
        send_score(32'h0000_0000, 16'd1, 1'b0);
        send_score(32'h0000_0001, 16'hAAAA, 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 1) == 1) begin
                repeat (3) send_score($urandom, 16'($urandom), 1'b0);
            end
            case (phase)
                0:       write_floor(stks_pkg::FLOOR_RESET);
                1:       write_floor($urandom);
                2:       write_floor(32'h8000_0000);
                3:       write_floor(32'h0000_0000);
                4:       write_floor(32'h7FFF_F000);
                default: write_floor(stks_pkg::FLOOR_RESET);
            endcase
            if (phase == 1) begin
                long_hold_req = 1'b1;
            end
            if (phase == RANDOM_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(25, 40);
                else
                    len = $urandom_range(1, 12);
                mode = score_mode_e'($urandom_range(0, 3));
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        pos = 16'($urandom);
                    else
                        pos = 16'(i);
                    send_score(pick_score(mode, i), pos, i == len - 1);
                end
                sent += len;
                if ($urandom_range(0, 9) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
